FILE: design/rdc_pkg.sv
`default_nettype none

package rdc_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int STACK_DEPTH = 32;

  // quotient bits resolved per divider cycle
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int PAD_WIDTH = DIV_STEPS * DIV_BITS;
  localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W  = $clog2(STACK_DEPTH);
  localparam int RADIX_W = 5;
  localparam int DIGIT_W = 4;
  localparam int BASE_W  = DIGIT_W + 1;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  typedef logic [PAD_WIDTH-1:0] quot_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic logic [BASE_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] c;
    c = r;
    if (r < RADIX_MIN) begin
      c = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      c = RADIX_MAX;
    end
    return BASE_W'(c);
  endfunction

endpackage

`default_nettype wire

FILE: design/rdc_ram.sv
`default_nettype none

module rdc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: design/rdc_divider.sv
`default_nettype none

module rdc_divider (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire rdc_pkg::quot_t                dividend,
  input  wire logic [rdc_pkg::BASE_W-1:0]    divisor,
  output rdc_pkg::quot_t                     quotient,
  output logic      [rdc_pkg::DIGIT_W-1:0]   remainder,
  output rdc_pkg::div_status_t               status
);

  import rdc_pkg::*;

  quot_t               quo;
  logic [DIGIT_W-1:0]  rem;
  logic [STEP_W-1:0]   step;
  logic                busy;
  logic                done;

  quot_t               quo_next;
  logic [DIGIT_W-1:0]  rem_next;
  logic [DIV_BITS-1:0] qbits;
  logic [BASE_W-1:0]   trial;
  logic [DIGIT_W-1:0]  part;

  // restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    part  = rem;
    trial = '0;
    qbits = '0;
    for (int i = DIV_BITS - 1; i >= 0; i--) begin
      trial = {part, quo[PAD_WIDTH - DIV_BITS + i]};
      if (trial >= divisor) begin
        trial    = trial - divisor;
        qbits[i] = 1'b1;
      end
      part = trial[DIGIT_W-1:0];
    end
    rem_next = part;
    quo_next = (quo << DIV_BITS) | quot_t'(qbits);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == STEP_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient    = quo;
  assign remainder   = rem;
  assign status.busy = busy;
  assign status.done = done;

endmodule

`default_nettype wire

FILE: design/radix_digit_converter.sv
`default_nettype none

// channel   direction  handshake            payload
// radix     in         radix_wr_en          radix_wr_data[4:0]
// input     in         in_valid / in_stall  value[31:0]
// digits    out        out_valid/out_stall  digit[3:0], last_digit
//
// one item produces n digits (1 to 32); each digit comes from the shared
// divider (8 quotient bits per cycle) and is pushed on the stack; the digits
// are then read back in reverse order through the read, load and send states
// in_stall stays high from acceptance until the last digit is taken
// synchronous reset sets radix to 10 and empties the stack
// out_stall holds the current digit and halts the sequencer

module radix_digit_converter (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              radix_wr_en,
  input  wire logic [rdc_pkg::RADIX_W-1:0]       radix_wr_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [rdc_pkg::VALUE_WIDTH-1:0]   value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [rdc_pkg::DIGIT_W-1:0]       digit,
  output logic                                   last_digit
);

  import rdc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_SEND = 3'd4;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [RADIX_W-1:0] radix;
  logic [BASE_W-1:0]  base;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [CNT_W-1:0]   count_dec;

  logic               div_start;
  quot_t              div_dividend;
  quot_t              div_quotient;
  logic [DIGIT_W-1:0] div_remainder;
  div_status_t        div_st;

  logic               stk_wr_en;
  logic [DIGIT_W-1:0] stk_rd_data;

  logic               accept;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign count_dec = count - 1'b1;
  assign stk_wr_en = (state == S_DIV) && div_st.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (radix_wr_en) begin
      radix <= radix_wr_data;
    end
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    div_start    = 1'b0;
    div_dividend = quot_t'(value);
    case (state)
      S_IDLE: begin
        if (accept) begin
          div_start  = 1'b1;
          count_next = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          count_next = count + 1'b1;
          if (div_quotient == '0 || count == CNT_W'(STACK_DEPTH - 1)) begin
            state_next = S_READ;
          end else begin
            div_start    = 1'b1;
            div_dividend = div_quotient;
          end
        end
      end
      S_READ: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        state_next = S_SEND;
      end
      S_SEND: begin
        if (!out_stall) begin
          count_next = count_dec;
          state_next = (count == CNT_W'(1)) ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_LOAD) begin
        out_valid <= 1'b1;
      end else if (state == S_SEND && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      base <= clamp_radix(radix);
    end
    if (state == S_LOAD) begin
      digit      <= stk_rd_data;
      last_digit <= (count == CNT_W'(1));
    end
  end

  rdc_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (base),
    .quotient  (div_quotient),
    .remainder (div_remainder),
    .status    (div_st)
  );

  rdc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (div_remainder),
    .rd_addr (count_dec[ADDR_W-1:0]),
    .rd_data (stk_rd_data)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("digit count beyond stack depth");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !div_st.busy && !out_valid)
    else $error("divider or output active while idle");

  a_last_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_digit |-> count == CNT_W'(1))
    else $error("last digit flagged with digits left");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> state == S_DIV)
    else $error("divider finished outside division phase");

endmodule

`default_nettype wire
